FILE: design/bed_level_motor_speed_law_defines.svh
// Assertion macros for the bed level motor speed law.
// The including module must provide clk and rst_n.
`ifndef BED_LEVEL_MOTOR_SPEED_LAW_DEFINES_SVH
`define BED_LEVEL_MOTOR_SPEED_LAW_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BLMSL_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("blmsl: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BLMSL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("blmsl: next-cycle check failed");

`endif

FILE: design/blmsl_pkg.sv
// Package for the bed level motor speed law: payload, configuration and queue types,
// register indexes, reset values and small arithmetic helpers. No dependencies.
`default_nettype none

package blmsl_pkg;

  localparam int NUM_MOTORS_DEF  = 4;
  localparam int SPEED_FLOOR_DEF = 328;
  localparam int Q_DEPTH_DEF     = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LIMIT_W    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ROLL_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_FRACTION    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WITHIN_TOLERANCE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_POLARITY  = 3'd6;

  localparam logic [15:0] ROLL_GAIN_RST        = 16'd614;
  localparam logic [15:0] PITCH_GAIN_RST       = 16'd614;
  localparam logic [14:0] DEAD_BAND_RST        = 15'd64;
  localparam logic [14:0] SPEED_LIMIT_RST      = 15'd4096;
  localparam logic [12:0] TRIM_FRACTION_RST    = 13'd614;
  localparam logic [14:0] WITHIN_TOLERANCE_RST = 15'd128;
  localparam logic [11:0] CORNER_POLARITY_RST  = 12'd0;

  localparam logic FUNC_LEVEL = 1'b0;
  localparam logic FUNC_TRIM  = 1'b1;

  typedef struct packed {
    logic              func;
    logic              front_ok;
    logic signed [15:0] front_pitch;
    logic signed [15:0] front_roll;
    logic              rear_ok;
    logic signed [15:0] rear_pitch;
    logic signed [15:0] rear_roll;
    logic [14:0]       group_speed;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         motor_index;
    logic signed [15:0] velocity;
    logic               in_deadband;
    logic               within_target;
    logic               sensors_ok;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] roll_gain;
    logic [15:0] pitch_gain;
    logic [14:0] dead_band;
    logic [14:0] speed_limit;
    logic [12:0] trim_fraction;
    logic [14:0] within_tolerance;
    logic [11:0] corner_polarity;
  } cfg_t;

  // One classified sample, as handed from the front end to the back end.
  typedef struct packed {
    logic               func;
    logic               sensors_ok;
    logic               in_deadband;
    logic               within_target;
    logic signed [15:0] front_err;
    logic signed [15:0] rear_err;
    logic signed [15:0] pitch_err;
    logic [LIMIT_W-1:0] limit;
  } cls_t;

  // Per-result tag that travels down the back-end pipeline.
  typedef struct packed {
    logic [2:0]         motor_index;
    logic               last;
    logic               func;
    logic [LIMIT_W-1:0] limit;
    logic               in_deadband;
    logic               within_target;
    logic               sensors_ok;
  } tag_t;

  function automatic logic signed [15:0] dead_band_of(logic signed [15:0] e,
                                                      logic [14:0] db);
    logic signed [16:0] e17;
    logic signed [16:0] d17;
    logic signed [16:0] res;
    e17 = {e[15], e};
    d17 = {2'b00, db};
    if (e17 > d17) begin
      res = e17 - d17;
    end else if (e17 < -d17) begin
      res = e17 + d17;
    end else begin
      res = '0;
    end
    return res[15:0];
  endfunction

  function automatic logic [16:0] abs17(logic signed [16:0] x);
    logic signed [16:0] neg;
    neg = -x;
    return x[16] ? neg : x;
  endfunction

  // Polarity bits of a motor; motors above the register's reach are rear, both signs negative.
  function automatic logic [2:0] pol_of(logic [11:0] cp, logic [2:0] idx);
    logic [2:0] res;
    case (idx)
      3'd0: res = cp[2:0];
      3'd1: res = cp[5:3];
      3'd2: res = cp[8:6];
      3'd3: res = cp[11:9];
      default: res = 3'b000;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/blmsl_front.sv
// Front end of the bed level motor speed law: registers an accepted sample with its
// deadband errors, flags and trim product, and forms the queue entry. Uses blmsl_pkg.
`default_nettype none

module blmsl_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire blmsl_pkg::cfg_t  cfg,
  input  wire logic             accept,
  input  wire blmsl_pkg::in_item_t in_item,
  output logic                  push,
  output blmsl_pkg::cls_t       push_data
);

  logic               a_valid_r;
  logic               a_func_r;
  logic               a_ok_r;
  logic               a_indb_r;
  logic               a_within_r;
  logic signed [15:0] a_ferr_r;
  logic signed [15:0] a_rerr_r;
  logic signed [15:0] a_perr_r;
  logic [27:0]        a_prod_r;

  logic signed [16:0] pitch_sum;
  logic signed [15:0] mean;
  logic signed [16:0] fr17;
  logic signed [16:0] rr17;
  logic signed [16:0] twist;
  logic [16:0]        tol17;
  logic               ok;
  logic signed [15:0] ferr;
  logic signed [15:0] rerr;
  logic signed [15:0] perr;
  logic [28:0]        trim_rnd;

  always_comb begin
    pitch_sum = {in_item.front_pitch[15], in_item.front_pitch}
              + {in_item.rear_pitch[15], in_item.rear_pitch};
    mean  = pitch_sum[16:1];
    fr17  = {in_item.front_roll[15], in_item.front_roll};
    rr17  = {in_item.rear_roll[15], in_item.rear_roll};
    twist = fr17 - rr17;
    tol17 = {2'b00, cfg.within_tolerance};
    ok    = in_item.front_ok & in_item.rear_ok;
    ferr  = blmsl_pkg::dead_band_of(in_item.front_roll, cfg.dead_band);
    rerr  = blmsl_pkg::dead_band_of(in_item.rear_roll, cfg.dead_band);
    perr  = blmsl_pkg::dead_band_of(mean, cfg.dead_band);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_func_r   <= in_item.func;
      a_ok_r     <= ok;
      a_ferr_r   <= ferr;
      a_rerr_r   <= rerr;
      a_perr_r   <= perr;
      a_indb_r   <= ok && (ferr == '0) && (rerr == '0) && (perr == '0);
      a_within_r <= ok
                 && (blmsl_pkg::abs17(fr17) < tol17)
                 && (blmsl_pkg::abs17(rr17) < tol17)
                 && (blmsl_pkg::abs17({mean[15], mean}) < tol17)
                 && (blmsl_pkg::abs17(twist) < tol17);
      a_prod_r   <= cfg.trim_fraction * in_item.group_speed;
    end
  end

  always_comb begin
    trim_rnd                = {1'b0, a_prod_r} + 29'd2048;
    push                    = a_valid_r;
    push_data.func          = a_func_r;
    push_data.sensors_ok    = a_ok_r;
    push_data.in_deadband   = a_indb_r;
    push_data.within_target = a_within_r;
    push_data.front_err     = a_ferr_r;
    push_data.rear_err      = a_rerr_r;
    push_data.pitch_err     = a_perr_r;
    if (a_func_r == blmsl_pkg::FUNC_TRIM) begin
      push_data.limit = trim_rnd[28:12];
    end else begin
      push_data.limit = {2'b00, cfg.speed_limit};
    end
  end

endmodule

`default_nettype wire

FILE: design/blmsl_queue.sv
// Small first-word-fall-through queue of classified samples between the front and
// back ends of the bed level motor speed law. Uses blmsl_pkg.
`default_nettype none

module blmsl_queue #(
  parameter int DEPTH = blmsl_pkg::Q_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire blmsl_pkg::cls_t            push_data,
  input  wire logic                       pop,
  output blmsl_pkg::cls_t                 head,
  output logic                            not_empty,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH-1);

  blmsl_pkg::cls_t entries_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  assign head      = entries_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

`default_nettype wire

FILE: design/blmsl_back.sv
// Back end of the bed level motor speed law: steps through the motors of each queued
// sample and runs the multiply, round, floor, clamp pipeline. Uses blmsl_pkg.
`default_nettype none

module blmsl_back #(
  parameter int NUM_MOTORS  = blmsl_pkg::NUM_MOTORS_DEF,
  parameter int SPEED_FLOOR = blmsl_pkg::SPEED_FLOOR_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire blmsl_pkg::cfg_t       cfg,
  input  wire logic                  q_valid,
  input  wire blmsl_pkg::cls_t       q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  output blmsl_pkg::out_item_t       out_item
);

  localparam logic [2:0]         LAST_IDX = 3'(NUM_MOTORS - 1);
  localparam logic signed [26:0] FLOOR_V  = 27'(SPEED_FLOOR);

  // Sequencer over the motors of the current sample.
  logic            cur_valid_r;
  logic            cur_valid_nxt;
  blmsl_pkg::cls_t cur_r;
  logic [2:0]      motor_r;
  logic [2:0]      motor_nxt;
  logic            at_last;

  // Operand stage.
  logic               i_valid_r;
  blmsl_pkg::tag_t    i_tag_r;
  logic signed [16:0] i_opr_r;
  logic signed [16:0] i_opp_r;
  blmsl_pkg::tag_t    i_tag;
  logic [2:0]         pol;
  logic signed [15:0] r_sel;
  logic signed [16:0] r17;
  logic signed [16:0] p17;
  logic signed [16:0] opr;
  logic signed [16:0] opp;

  // Multiply stage.
  logic               m_valid_r;
  blmsl_pkg::tag_t    m_tag_r;
  logic signed [33:0] m_roll_r;
  logic signed [33:0] m_pitch_r;

  // Round stage.
  logic               r_valid_r;
  blmsl_pkg::tag_t    r_tag_r;
  logic signed [26:0] r_v_r;
  logic               r_pos_r;
  logic               r_neg_r;
  logic signed [34:0] sum;
  logic signed [34:0] rnd;

  // Output stage.
  logic                 out_valid_r;
  blmsl_pkg::out_item_t out_item_r;
  logic signed [26:0]   lim27;
  logic signed [26:0]   fl;
  logic signed [26:0]   cl;
  logic signed [15:0]   sat;

  assign at_last = (motor_r == LAST_IDX);
  assign q_pop   = q_valid && (!cur_valid_r || at_last);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    motor_nxt     = motor_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      motor_nxt     = '0;
    end else if (cur_valid_r && at_last) begin
      cur_valid_nxt = 1'b0;
    end else if (cur_valid_r) begin
      motor_nxt = motor_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      motor_r     <= '0;
      i_valid_r   <= 1'b0;
      m_valid_r   <= 1'b0;
      r_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      motor_r     <= motor_nxt;
      i_valid_r   <= cur_valid_r;
      m_valid_r   <= i_valid_r;
      r_valid_r   <= m_valid_r;
      out_valid_r <= r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  // The operands carry the sign of the final sum, so the products add directly.
  always_comb begin
    pol   = blmsl_pkg::pol_of(cfg.corner_polarity, motor_r);
    r_sel = pol[0] ? cur_r.front_err : cur_r.rear_err;
    r17   = {r_sel[15], r_sel};
    p17   = {cur_r.pitch_err[15], cur_r.pitch_err};
    opr   = pol[1] ? r17 : -r17;
    opp   = pol[2] ? p17 : -p17;
    if (!cur_r.sensors_ok) begin
      opr = '0;
      opp = '0;
    end
    i_tag.motor_index   = motor_r;
    i_tag.last          = at_last;
    i_tag.func          = cur_r.func;
    i_tag.limit         = cur_r.limit;
    i_tag.in_deadband   = cur_r.in_deadband;
    i_tag.within_target = cur_r.within_target;
    i_tag.sensors_ok    = cur_r.sensors_ok;
  end

  always_ff @(posedge clk) begin
    i_tag_r   <= i_tag;
    i_opr_r   <= opr;
    i_opp_r   <= opp;
    m_tag_r   <= i_tag_r;
    m_roll_r  <= $signed({1'b0, cfg.roll_gain}) * i_opr_r;
    m_pitch_r <= $signed({1'b0, cfg.pitch_gain}) * i_opp_r;
  end

  always_comb begin
    sum = {m_roll_r[33], m_roll_r} + {m_pitch_r[33], m_pitch_r};
    rnd = sum + 35'sd128;
  end

  always_ff @(posedge clk) begin
    r_tag_r <= m_tag_r;
    r_v_r   <= rnd[34:8];
    r_pos_r <= !sum[34] && (sum != '0);
    r_neg_r <= sum[34];
  end

  always_comb begin
    lim27 = {10'b0, r_tag_r.limit};
    fl    = r_v_r;
    if (r_tag_r.func == blmsl_pkg::FUNC_LEVEL) begin
      if (r_pos_r && (r_v_r < FLOOR_V)) begin
        fl = FLOOR_V;
      end
      if (r_neg_r && (r_v_r > -FLOOR_V)) begin
        fl = -FLOOR_V;
      end
    end
    if (fl > lim27) begin
      cl = lim27;
    end else if (fl < -lim27) begin
      cl = -lim27;
    end else begin
      cl = fl;
    end
    if (cl > 27'sd32767) begin
      sat = 16'sh7FFF;
    end else if (cl < -27'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = cl[15:0];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.motor_index   <= r_tag_r.motor_index;
    out_item_r.velocity      <= sat;
    out_item_r.in_deadband   <= r_tag_r.in_deadband;
    out_item_r.within_target <= r_tag_r.within_target;
    out_item_r.sensors_ok    <= r_tag_r.sensors_ok;
    out_item_r.last          <= r_tag_r.last;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

FILE: design/bed_level_motor_speed_law.sv
// Top level of the bed level motor speed law: configuration registers, front end,
// sample queue and back end. Uses blmsl_pkg, blmsl_front, blmsl_queue, blmsl_back.
`default_nettype none

// A sample is taken when start is high and busy is low. Each sample yields NUM_MOTORS
// results, one per clock on consecutive cycles, each marked by out_valid for exactly one
// cycle; the receiver cannot stall them. The back end's motor sequencer emits one result
// per cycle; the first result of a sample passes the front register, the queue, the
// sequencer and the operand, multiply, round and output stages to the outputs. A queue
// of Q_DEPTH samples lets new samples be taken while results still flow; busy rises only
// when the queued samples plus the front register's sample reach Q_DEPTH. Configuration
// registers are written through cfg_we at any edge and should change only while idle.

module bed_level_motor_speed_law #(
  parameter int NUM_MOTORS  = blmsl_pkg::NUM_MOTORS_DEF,
  parameter int SPEED_FLOOR = blmsl_pkg::SPEED_FLOOR_DEF,
  parameter int Q_DEPTH     = blmsl_pkg::Q_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire blmsl_pkg::in_item_t               in_item,
  output logic                                   out_valid,
  output blmsl_pkg::out_item_t                   out_item,
  input  wire logic                              cfg_we,
  input  wire logic [blmsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [blmsl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

`include "bed_level_motor_speed_law_defines.svh"

  localparam int CW = $clog2(Q_DEPTH+1);

  blmsl_pkg::cfg_t cfg_r;
  blmsl_pkg::cfg_t cfg_nxt;

  logic            accept;
  logic            a_valid;
  blmsl_pkg::cls_t push_data;
  logic            q_pop;
  logic            q_valid;
  blmsl_pkg::cls_t q_head;
  logic [CW-1:0]   q_count;
  logic [CW:0]     credit;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        blmsl_pkg::REG_ROLL_GAIN:        cfg_nxt.roll_gain        = cfg_wdata;
        blmsl_pkg::REG_PITCH_GAIN:       cfg_nxt.pitch_gain       = cfg_wdata;
        blmsl_pkg::REG_DEAD_BAND:        cfg_nxt.dead_band        = cfg_wdata[14:0];
        blmsl_pkg::REG_SPEED_LIMIT:      cfg_nxt.speed_limit      = cfg_wdata[14:0];
        blmsl_pkg::REG_TRIM_FRACTION:    cfg_nxt.trim_fraction    = cfg_wdata[12:0];
        blmsl_pkg::REG_WITHIN_TOLERANCE: cfg_nxt.within_tolerance = cfg_wdata[14:0];
        blmsl_pkg::REG_CORNER_POLARITY:  cfg_nxt.corner_polarity  = cfg_wdata[11:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.roll_gain        <= blmsl_pkg::ROLL_GAIN_RST;
      cfg_r.pitch_gain       <= blmsl_pkg::PITCH_GAIN_RST;
      cfg_r.dead_band        <= blmsl_pkg::DEAD_BAND_RST;
      cfg_r.speed_limit      <= blmsl_pkg::SPEED_LIMIT_RST;
      cfg_r.trim_fraction    <= blmsl_pkg::TRIM_FRACTION_RST;
      cfg_r.within_tolerance <= blmsl_pkg::WITHIN_TOLERANCE_RST;
      cfg_r.corner_polarity  <= blmsl_pkg::CORNER_POLARITY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign credit = {1'b0, q_count} + {{CW{1'b0}}, a_valid};
  assign busy   = (credit >= (CW+1)'(Q_DEPTH));
  assign accept = start && !busy;

  blmsl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .in_item   (in_item),
    .push      (a_valid),
    .push_data (push_data)
  );

  blmsl_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (a_valid),
    .push_data (push_data),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid),
    .count     (q_count)
  );

  blmsl_back #(
    .NUM_MOTORS  (NUM_MOTORS),
    .SPEED_FLOOR (SPEED_FLOOR)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `BLMSL_ASSERT_IMP(a_queue_credit, 1'b1, credit <= (CW+1)'(Q_DEPTH))
  `BLMSL_ASSERT_IMP(a_pop_nonempty, q_pop, q_valid)
  `BLMSL_ASSERT_IMP(a_bad_sensor_zero, out_valid && !out_item.sensors_ok, out_item.velocity == '0)
  `BLMSL_ASSERT_NEXT(a_burst_contiguous, out_valid && !out_item.last, out_valid)

endmodule

`default_nettype wire
